>>> sv/bfrp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfrp_pkg
// Types and constants shared by the best-fit row packer and its cells.
// ----------------------------------------------------------------------------
package bfrp_pkg;

   localparam int          WORD_CHARS = 10;
   localparam int          CNT_W      = 4;
   localparam logic [7:0]  FREE_MARK  = 8'd43;

   typedef enum logic [1:0] {
      ST_PLACED   = 2'd0,
      ST_TOO_LONG = 2'd1,
      ST_NO_ROOM  = 2'd2
   } status_type;

   typedef struct packed {
      logic [15:0]      word_chars_high;
      logic [63:0]      word_chars_low;
      logic [CNT_W-1:0] word_length;
   } req_type;

   typedef struct packed {
      status_type       status;
      logic [CNT_W-1:0] slot_rank;
      logic [CNT_W-1:0] start_column;
      logic [CNT_W-1:0] free_after;
   } rsp_type;

   // Flags handed from one rank cell to the next one up.
   typedef struct packed {
      logic fits;   // some lower rank holds the word
      logic gt;     // some lower rank has more free than the updated row
   } link_type;

   // Broadcast from the top level to every cell.
   typedef struct packed {
      logic             place;
      logic [CNT_W-1:0] len;
      logic [CNT_W-1:0] new_free;
   } ctl_type;

endpackage

>>> sv/bfrp_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfrp_cell
// One rank slot: holds a row's free count and characters, finds whether it
// is the best-fit row, and shifts up by one rank when a refilled row drops
// below it.
// ----------------------------------------------------------------------------
module bfrp_cell #(
   parameter int ROW_LENGTH = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bfrp_pkg::link_type            link_in,
   output bfrp_pkg::link_type            link_out,
   input  bfrp_pkg::ctl_type             ctl,
   input  logic [ROW_LENGTH*8-1:0]       new_row,
   input  logic [ROW_LENGTH*8-1:0]       prev_row,
   input  logic [bfrp_pkg::CNT_W-1:0]    prev_free,
   output logic [bfrp_pkg::CNT_W-1:0]    free_out,
   output logic [ROW_LENGTH*8-1:0]       row_out,
   output logic                          hit
);
   import bfrp_pkg::*;

   logic [CNT_W-1:0]        free_ff, free_in;
   logic [ROW_LENGTH*8-1:0] row_ff, row_in;
   logic                    fits, gt, in_region;

   always_comb begin
      fits      = free_ff >= ctl.len;
      gt        = free_ff > ctl.new_free;
      hit       = fits && !link_in.fits;
      in_region = !link_in.fits;   // at or below the chosen rank
      link_out.fits = fits || link_in.fits;
      link_out.gt   = gt || link_in.gt;

      free_in = free_ff;
      row_in  = row_ff;
      if (ctl.place && in_region) begin
         if (link_in.gt) begin
            // shift up to make room for the refilled row below
            free_in = prev_free;
            row_in  = prev_row;
         end else if (gt || hit) begin
            free_in = ctl.new_free;
            row_in  = new_row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff <= CNT_W'(ROW_LENGTH);
         row_ff  <= {ROW_LENGTH{FREE_MARK}};
      end else begin
         free_ff <= free_in;
         row_ff  <= row_in;
      end
   end

   assign free_out = free_ff;
   assign row_out  = row_ff;

endmodule

>>> sv/bfrp_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfrp_merge
// Builds the chosen row with the word's characters appended from its first
// free column.
// ----------------------------------------------------------------------------
module bfrp_merge #(
   parameter int ROW_LENGTH = 10
) (
   input  logic [ROW_LENGTH*8-1:0]                     row_in,
   input  logic [bfrp_pkg::CNT_W-1:0]                  start,
   input  logic [bfrp_pkg::CNT_W-1:0]                  len,
   input  logic [bfrp_pkg::WORD_CHARS-1:0][7:0]        chars,
   output logic [ROW_LENGTH*8-1:0]                     row_out
);
   import bfrp_pkg::*;

   always_comb begin
      logic [CNT_W-1:0] k;
      row_out = row_in;
      for (int c = 0; c < ROW_LENGTH; c++) begin
         k = CNT_W'(c) - start;
         if (CNT_W'(c) >= start && k < len && k < CNT_W'(WORD_CHARS)) begin
            row_out[c*8 +: 8] = chars[k];
         end
      end
   end

endmodule

>>> sv/best_fit_row_packer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_fit_row_packer
// Packs words of up to ten characters into rows by best fit.
// ----------------------------------------------------------------------------
// The packer takes one request per cycle and answers each with one response,
// registered, in the cycle after acceptance; it keeps taking requests while
// the response register drains, so throughput is one word per clock unless
// the response side stalls. The rows live in a chain of ROW_COUNT rank cells
// kept sorted by free space. Each cycle every cell checks its fit in
// parallel, the lowest fitting cell is the chosen row, and the cells between
// the new position of that row and its old rank shift up by one in the same
// edge, so the whole re-rank completes at that same edge.
// ----------------------------------------------------------------------------
module best_fit_row_packer #(
   parameter int ROW_LENGTH = 10,
   parameter int ROW_COUNT  = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bfrp_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bfrp_pkg::rsp_type rsp_payload
);
   import bfrp_pkg::*;

   localparam int ROW_W = ROW_LENGTH * 8;

   link_type                  link [ROW_COUNT+1];
   logic [CNT_W-1:0]          free_q [ROW_COUNT];
   logic [ROW_W-1:0]          row_q [ROW_COUNT];
   logic [CNT_W-1:0]          prev_free [ROW_COUNT];
   logic [ROW_W-1:0]          prev_row [ROW_COUNT];
   logic [ROW_COUNT-1:0]      hit;

   logic [CNT_W-1:0]          sel_free, sel_rank, start, len;
   logic [ROW_W-1:0]          sel_row, new_row;
   logic                      found, too_long, req_accept;
   ctl_type                   ctl;
   logic [WORD_CHARS-1:0][7:0] chars;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   assign len        = req_payload.word_length;
   assign chars      = {req_payload.word_chars_high, req_payload.word_chars_low};
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;
   assign link[0]    = '0;
   assign found      = link[ROW_COUNT].fits;
   assign too_long   = len > CNT_W'(ROW_LENGTH);

   always_comb begin
      for (int i = 0; i < ROW_COUNT; i++) begin
         if (i == 0) begin
            prev_free[i] = '0;
            prev_row[i]  = '0;
         end else begin
            prev_free[i] = free_q[i-1];
            prev_row[i]  = row_q[i-1];
         end
      end
   end

   // Gather the chosen row; hit is one-hot or empty.
   always_comb begin
      sel_free = '0;
      sel_row  = '0;
      sel_rank = '0;
      for (int i = 0; i < ROW_COUNT; i++) begin
         if (hit[i]) begin
            sel_free = sel_free | free_q[i];
            sel_row  = sel_row | row_q[i];
            sel_rank = sel_rank | CNT_W'(i);
         end
      end
   end

   assign start        = CNT_W'(ROW_LENGTH) - sel_free;
   assign ctl.place    = req_accept && !too_long && found;
   assign ctl.len      = len;
   assign ctl.new_free = sel_free - len;

   bfrp_merge #(.ROW_LENGTH(ROW_LENGTH)) u_merge (
      .row_in  (sel_row),
      .start   (start),
      .len     (len),
      .chars   (chars),
      .row_out (new_row)
   );

   for (genvar g = 0; g < ROW_COUNT; g++) begin : g_cell
      bfrp_cell #(.ROW_LENGTH(ROW_LENGTH)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .link_in   (link[g]),
         .link_out  (link[g+1]),
         .ctl       (ctl),
         .new_row   (new_row),
         .prev_row  (prev_row[g]),
         .prev_free (prev_free[g]),
         .free_out  (free_q[g]),
         .row_out   (row_q[g]),
         .hit       (hit[g])
      );
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '0;
         if (too_long) begin
            rsp_in.status = ST_TOO_LONG;
         end else if (!found) begin
            rsp_in.status = ST_NO_ROOM;
         end else begin
            rsp_in.status       = ST_PLACED;
            rsp_in.slot_rank    = sel_rank;
            rsp_in.start_column = start;
            rsp_in.free_after   = ctl.new_free;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

>>> sv/bfrp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfrp_checker
// Port-level checks for the best-fit row packer, bound to the top level.
// ----------------------------------------------------------------------------
module bfrp_checker #(
   parameter int ROW_LENGTH = 10,
   parameter int ROW_COUNT  = 10
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic [bfrp_pkg::CNT_W-1:0] req_length,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input bfrp_pkg::rsp_type          rsp_payload
);
   import bfrp_pkg::*;

   // Hold a stalled response.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed while stalled");

   // Every accepted request shows its response next cycle; too long iff over a row.
   a_too_long: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid &&
         ((rsp_payload.status == ST_TOO_LONG) ==
          ($past(req_length) > CNT_W'(ROW_LENGTH))))
      else $error("too-long status does not match request length");

   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != ST_PLACED |->
         rsp_payload.slot_rank == '0 && rsp_payload.start_column == '0 &&
         rsp_payload.free_after == '0)
      else $error("refused response carries nonzero fields");

   a_placed_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == ST_PLACED |->
         rsp_payload.slot_rank < CNT_W'(ROW_COUNT) &&
         ({1'b0, rsp_payload.start_column} + {1'b0, rsp_payload.free_after})
            <= (CNT_W+1)'(ROW_LENGTH))
      else $error("placed response out of row bounds");

endmodule

bind best_fit_row_packer bfrp_checker #(
   .ROW_LENGTH (ROW_LENGTH),
   .ROW_COUNT  (ROW_COUNT)
) u_bfrp_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_length  (req_payload.word_length),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
